>>> rtl/psfm_pkg.sv
// ----------------------------------------------------------------------------
// psfm_pkg: Packet sequence freshness monitor shared definitions
// Transfer payload types, configuration bundle, event codes and the
// constants of the divide-by-1000 pipeline.
// ----------------------------------------------------------------------------
package psfm_pkg;

	localparam int APB_AW = 4;

	localparam logic OP_ARRIVAL = 1'b0;
	localparam logic OP_READ    = 1'b1;

	localparam logic [2:0] EV_FIRST       = 3'd0;
	localparam logic [2:0] EV_IN_ORDER    = 3'd1;
	localparam logic [2:0] EV_LOST        = 3'd2;
	localparam logic [2:0] EV_REPEAT      = 3'd3;
	localparam logic [2:0] EV_RECOVERED   = 3'd4;
	localparam logic [2:0] EV_BACK_OK     = 3'd5;
	localparam logic [2:0] EV_BACK_EXCESS = 3'd6;

	// Long division by 1000, one 16-bit chunk per step. The reciprocal is
	// ceil(2^36 / 1000); it is exact for every partial dividend below 2^26.
	localparam int DIV_CHUNK_W = 16;
	localparam int DIV_REM_W   = 10;
	localparam int DIV_V_W     = DIV_REM_W + DIV_CHUNK_W;
	localparam int DIV_M_W     = 27;
	localparam int DIV_SHIFT   = 36;
	localparam logic [DIV_M_W-1:0] DIV_RECIP = 27'd68719477;

	typedef struct packed {
		logic        operation;
		logic [31:0] packet_counter;
		logic [63:0] send_time_ns;
		logic [31:0] now_us;
	} psfm_in_t;

	typedef struct packed {
		logic [31:0] sample_number;
		logic [2:0]  event_code;
		logic        period_deviation;
		logic        stale;
		logic [31:0] lost_events;
		logic [31:0] repeat_events;
		logic [31:0] recovery_events;
		logic [31:0] rollover_events;
		logic [31:0] deviation_events;
		logic [31:0] stale_events;
		logic [63:0] packet_time_us;
	} psfm_out_t;

	typedef struct packed {
		logic [30:0] max_data_age_us;
		logic [30:0] max_lost_tolerance;
		logic [30:0] producer_period_us;
	} psfm_cfg_t;

	// Item as it leaves the front pipeline for the state stage.
	typedef struct packed {
		logic        operation;
		logic [31:0] packet_counter;
		logic [31:0] now_us;
		logic [63:0] send_us;
		logic [63:0] counter_prod;
		logic [31:0] time_diff;
	} psfm_item_t;

endpackage

>>> rtl/psfm_regs.sv
// ----------------------------------------------------------------------------
// psfm_regs: Configuration register file
// APB-style slave holding the data age limit, the backward jump tolerance
// and the producer period. Zero wait states.
// ----------------------------------------------------------------------------
module psfm_regs import psfm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output psfm_cfg_t         cfg
);

	localparam logic [1:0] REG_MAX_AGE   = 2'd0;
	localparam logic [1:0] REG_TOLERANCE = 2'd1;
	localparam logic [1:0] REG_PERIOD    = 2'd2;
	localparam logic [1:0] REG_UNUSED    = 2'd3;

	logic [1:0]  reg_idx;
	logic        wr_en;
	psfm_cfg_t   cfg_q;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_data_age_us    <= 31'd20000;
			cfg_q.max_lost_tolerance <= 31'd4;
			cfg_q.producer_period_us <= 31'd0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAX_AGE:   cfg_q.max_data_age_us    <= pwdata[30:0];
				REG_TOLERANCE: cfg_q.max_lost_tolerance <= pwdata[30:0];
				REG_PERIOD:    cfg_q.producer_period_us <= pwdata[30:0];
				REG_UNUSED:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MAX_AGE:   prdata = {1'b0, cfg_q.max_data_age_us};
			REG_TOLERANCE: prdata = {1'b0, cfg_q.max_lost_tolerance};
			REG_PERIOD:    prdata = {1'b0, cfg_q.producer_period_us};
			REG_UNUSED:    prdata = 32'd0;
		endcase
	end

endmodule

>>> rtl/psfm_div_step.sv
// ----------------------------------------------------------------------------
// psfm_div_step: One step of the divide-by-1000 pipeline
// Takes the previous partial dividend and quotient digit, forms the
// remainder, appends the next 16-bit chunk and produces the next digit
// by a reciprocal multiplication.
// ----------------------------------------------------------------------------
module psfm_div_step import psfm_pkg::*; (
	input  logic [DIV_V_W-1:0]     v_prev,
	input  logic [DIV_CHUNK_W-1:0] q_prev,
	input  logic [DIV_CHUNK_W-1:0] chunk,
	output logic [DIV_V_W-1:0]     v,
	output logic [DIV_CHUNK_W-1:0] q
);

	logic [DIV_V_W-1:0]         q_ext;
	logic [DIV_V_W-1:0]         q_scaled;
	logic [DIV_V_W-1:0]         rem_full;
	logic [DIV_V_W+DIV_M_W-1:0] prod;

	// Multiplying by 1000 is 1024 - 16 - 8.
	assign q_ext    = {{DIV_REM_W{1'b0}}, q_prev};
	assign q_scaled = (q_ext << 10) - (q_ext << 4) - (q_ext << 3);
	assign rem_full = v_prev - q_scaled;
	assign v        = {rem_full[DIV_REM_W-1:0], chunk};
	assign prod     = (DIV_V_W+DIV_M_W)'(v) * (DIV_V_W+DIV_M_W)'(DIV_RECIP);
	assign q        = prod[DIV_SHIFT +: DIV_CHUNK_W];

endmodule

>>> rtl/psfm_front.sv
// ----------------------------------------------------------------------------
// psfm_front: Input register and precompute pipeline
// Five stages that convert the send time to microseconds and form the
// counter-times-period product and the arrival time difference, so that
// the state stage need not form them itself.
// ----------------------------------------------------------------------------
module psfm_front import psfm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  psfm_cfg_t  cfg,
	input  logic       item_valid,
	output logic       item_stall,
	input  psfm_in_t   item,
	output logic       pipe_valid,
	input  logic       pipe_ready,
	output psfm_item_t pipe_item
);

	typedef struct packed {
		psfm_in_t                  in;
		logic [63:0]               quot;
		logic [DIV_V_W-1:0]        v;
		logic [63:0]               counter_prod;
		logic [31:0]               time_diff;
	} psfm_stage_t;

	psfm_stage_t stage_s1, stage_s2, stage_s3, stage_s4, stage_s5;
	psfm_stage_t nxt_s1, nxt_s2, nxt_s3, nxt_s4, nxt_s5;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic        load_s1, load_s2, load_s3, load_s4, load_s5;

	logic [DIV_V_W-1:0]     v_a, v_b, v_c, v_d;
	logic [DIV_CHUNK_W-1:0] q_a, q_b, q_c, q_d;
	logic [62:0]            cnt_mul;

	assign load_s5    = !vld_s5 || pipe_ready;
	assign load_s4    = !vld_s4 || load_s5;
	assign load_s3    = !vld_s3 || load_s4;
	assign load_s2    = !vld_s2 || load_s3;
	assign load_s1    = !vld_s1 || load_s2;
	assign item_stall = !load_s1;

	psfm_div_step u_step_a (
		.v_prev (DIV_V_W'(0)),
		.q_prev (DIV_CHUNK_W'(0)),
		.chunk  (stage_s1.in.send_time_ns[63:48]),
		.v      (v_a),
		.q      (q_a)
	);

	psfm_div_step u_step_b (
		.v_prev (stage_s2.v),
		.q_prev (stage_s2.quot[15:0]),
		.chunk  (stage_s2.in.send_time_ns[47:32]),
		.v      (v_b),
		.q      (q_b)
	);

	psfm_div_step u_step_c (
		.v_prev (stage_s3.v),
		.q_prev (stage_s3.quot[15:0]),
		.chunk  (stage_s3.in.send_time_ns[31:16]),
		.v      (v_c),
		.q      (q_c)
	);

	psfm_div_step u_step_d (
		.v_prev (stage_s4.v),
		.q_prev (stage_s4.quot[15:0]),
		.chunk  (stage_s4.in.send_time_ns[15:0]),
		.v      (v_d),
		.q      (q_d)
	);

	assign cnt_mul = 63'(stage_s1.in.packet_counter) * 63'(cfg.producer_period_us);

	always_comb begin
		nxt_s1              = '0;
		nxt_s1.in           = item;

		nxt_s2              = stage_s1;
		nxt_s2.v            = v_a;
		nxt_s2.quot         = {stage_s1.quot[47:0], q_a};
		nxt_s2.counter_prod = {1'b0, cnt_mul};

		nxt_s3              = stage_s2;
		nxt_s3.v            = v_b;
		nxt_s3.quot         = {stage_s2.quot[47:0], q_b};
		nxt_s3.time_diff    = stage_s2.in.now_us - stage_s2.counter_prod[31:0];

		nxt_s4              = stage_s3;
		nxt_s4.v            = v_c;
		nxt_s4.quot         = {stage_s3.quot[47:0], q_c};

		nxt_s5              = stage_s4;
		nxt_s5.v            = v_d;
		nxt_s5.quot         = {stage_s4.quot[47:0], q_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (load_s1) begin
				vld_s1 <= item_valid;
			end
			if (load_s2) begin
				vld_s2 <= vld_s1;
			end
			if (load_s3) begin
				vld_s3 <= vld_s2;
			end
			if (load_s4) begin
				vld_s4 <= vld_s3;
			end
			if (load_s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			stage_s1 <= nxt_s1;
		end
		if (load_s2) begin
			stage_s2 <= nxt_s2;
		end
		if (load_s3) begin
			stage_s3 <= nxt_s3;
		end
		if (load_s4) begin
			stage_s4 <= nxt_s4;
		end
		if (load_s5) begin
			stage_s5 <= nxt_s5;
		end
	end

	assign pipe_valid             = vld_s5;
	assign pipe_item.operation    = stage_s5.in.operation;
	assign pipe_item.packet_counter = stage_s5.in.packet_counter;
	assign pipe_item.now_us       = stage_s5.in.now_us;
	assign pipe_item.send_us      = stage_s5.quot;
	assign pipe_item.counter_prod = stage_s5.counter_prod;
	assign pipe_item.time_diff    = stage_s5.time_diff;

endmodule

>>> rtl/psfm_core.sv
// ----------------------------------------------------------------------------
// psfm_core: Sequence and freshness state stage with result register
// Classifies arrivals, checks the arrival period and the data age at reads,
// updates the saturating event counters and registers the result.
// ----------------------------------------------------------------------------
module psfm_core import psfm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  psfm_cfg_t  cfg,
	input  logic       pipe_valid,
	output logic       pipe_ready,
	input  psfm_item_t pipe_item,
	output logic       result_valid,
	input  logic       result_stall,
	output psfm_out_t  result
);

	localparam int EV_CNT_N     = 6;
	localparam int CNT_LOST     = 0;
	localparam int CNT_REPEAT   = 1;
	localparam int CNT_RECOVERY = 2;
	localparam int CNT_ROLLOVER = 3;
	localparam int CNT_DEVIATION = 4;
	localparam int CNT_STALE    = 5;

	logic [31:0] last_id_q;
	logic        loss_pending_q;
	logic        fresh_q;
	logic [63:0] last_send_q;
	logic [31:0] base_q;
	logic [63:0] base_prod_q;
	logic [31:0] last_arrival_q;
	logic [31:0] ev_cnt_q   [EV_CNT_N];
	logic [31:0] ev_cnt_nxt [EV_CNT_N];
	logic [EV_CNT_N-1:0] bump;

	logic        result_valid_q;
	psfm_out_t   result_q;

	logic        take;
	logic        period_on;
	logic [31:0] dev_d;
	logic [31:0] dev_mag;
	logic [34:0] dev_ten;
	logic        dev_hit;
	logic [31:0] delta;
	logic        excess;
	logic [64:0] age_diff;
	logic [63:0] age;
	logic        too_old;
	logic [62:0] base_mul;

	logic [31:0] last_id_nxt;
	logic        loss_pending_nxt;
	logic        fresh_nxt;
	logic [63:0] last_send_nxt;
	logic        period_upd;
	psfm_out_t   res;
	psfm_out_t   res_out;

	assign pipe_ready = !result_valid_q || !result_stall;
	assign take       = pipe_valid && pipe_ready;
	assign period_on  = cfg.producer_period_us != 31'd0;

	assign dev_d   = pipe_item.time_diff + base_prod_q[31:0] - last_arrival_q;
	assign dev_mag = dev_d[31] ? (~dev_d + 32'd1) : dev_d;
	assign dev_ten = ({3'b000, dev_mag} << 3) + ({3'b000, dev_mag} << 1);
	assign dev_hit = dev_ten > {4'b0000, cfg.producer_period_us};

	assign delta  = pipe_item.packet_counter - last_id_q;
	assign excess = !pipe_item.packet_counter[31] &&
		(pipe_item.packet_counter[30:0] > cfg.max_lost_tolerance);

	assign age_diff = {33'd0, pipe_item.now_us} - {1'b0, last_send_q};
	assign age      = age_diff[64] ? (~age_diff[63:0] + 64'd1) : age_diff[63:0];
	assign too_old  = age > {33'd0, cfg.max_data_age_us};

	assign base_mul = 63'(base_q) * 63'(cfg.producer_period_us);

	always_comb begin
		last_id_nxt      = last_id_q;
		loss_pending_nxt = loss_pending_q;
		fresh_nxt        = fresh_q;
		last_send_nxt    = last_send_q;
		period_upd       = 1'b0;
		bump             = '0;
		res              = '0;

		if (pipe_item.operation == OP_ARRIVAL) begin
			res.sample_number = pipe_item.packet_counter;
			fresh_nxt         = 1'b1;
			if (period_on) begin
				period_upd           = 1'b1;
				res.period_deviation = dev_hit;
				bump[CNT_DEVIATION]  = dev_hit;
			end
			if (last_id_q == '1) begin
				res.event_code = EV_FIRST;
			end else if (delta[31]) begin
				res.event_code     = excess ? EV_BACK_EXCESS : EV_BACK_OK;
				bump[CNT_ROLLOVER] = excess;
			end else if (delta > 32'd1) begin
				res.event_code   = EV_LOST;
				bump[CNT_LOST]   = 1'b1;
				loss_pending_nxt = 1'b1;
			end else if (delta == 32'd0) begin
				res.event_code   = EV_REPEAT;
				bump[CNT_REPEAT] = 1'b1;
			end else if (loss_pending_q) begin
				res.event_code     = EV_RECOVERED;
				bump[CNT_RECOVERY] = 1'b1;
				loss_pending_nxt   = 1'b0;
			end else begin
				res.event_code = EV_IN_ORDER;
			end
			last_id_nxt   = pipe_item.packet_counter;
			last_send_nxt = pipe_item.send_us;
		end else begin
			res.sample_number = last_id_q;
			if (!fresh_q) begin
				res.stale = 1'b1;
			end else if (too_old) begin
				res.stale = 1'b1;
				fresh_nxt = 1'b0;
			end
			if (res.stale) begin
				res.sample_number = '1;
				bump[CNT_STALE]   = 1'b1;
			end
		end

		if (period_on) begin
			res.packet_time_us = period_upd ? pipe_item.counter_prod : base_prod_q;
		end else begin
			res.packet_time_us = last_send_nxt;
		end
	end

	always_comb begin
		res_out                  = res;
		res_out.lost_events      = ev_cnt_nxt[CNT_LOST];
		res_out.repeat_events    = ev_cnt_nxt[CNT_REPEAT];
		res_out.recovery_events  = ev_cnt_nxt[CNT_RECOVERY];
		res_out.rollover_events  = ev_cnt_nxt[CNT_ROLLOVER];
		res_out.deviation_events = ev_cnt_nxt[CNT_DEVIATION];
		res_out.stale_events     = ev_cnt_nxt[CNT_STALE];
	end

	for (genvar k = 0; k < EV_CNT_N; k++) begin : g_cnt
		assign ev_cnt_nxt[k] = (bump[k] && ev_cnt_q[k] != '1) ? ev_cnt_q[k] + 32'd1
			: ev_cnt_q[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ev_cnt_q[k] <= '0;
			end else if (take) begin
				ev_cnt_q[k] <= ev_cnt_nxt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_id_q      <= '1;
			loss_pending_q <= 1'b0;
			fresh_q        <= 1'b0;
			last_send_q    <= '0;
			base_q         <= '0;
			base_prod_q    <= '0;
			last_arrival_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				last_id_q      <= last_id_nxt;
				loss_pending_q <= loss_pending_nxt;
				fresh_q        <= fresh_nxt;
				last_send_q    <= last_send_nxt;
			end
			// The product tracks the base counter and follows any period write.
			if (take && period_upd) begin
				base_q         <= pipe_item.packet_counter;
				base_prod_q    <= pipe_item.counter_prod;
				last_arrival_q <= pipe_item.now_us;
			end else begin
				base_prod_q    <= {1'b0, base_mul};
			end
			if (pipe_ready) begin
				result_valid_q <= pipe_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= res_out;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> rtl/packet_sequence_freshness_monitor.sv
// ----------------------------------------------------------------------------
// packet_sequence_freshness_monitor: Packet sequence and freshness monitor
// Classifies received packets by sequence counter, checks arrival periods
// and reports whether the latest data is still fresh when it is read.
//
//   Channel   Direction  Handshake                  Payload
//   item      in         item_valid / item_stall    psfm_in_t
//   result    out        result_valid / result_stall psfm_out_t
//   config    in         APB psel/penable/pready    3 registers at 0x0, 0x4, 0x8
//
// One item is taken per cycle while item_stall is low; its result reaches
// the result register through an input register, four divide-by-1000 steps
// on the send time, and the state stage that writes the result register.
// Reset clears all pipeline valids, the sequence state and the counters.
// A stalled result holds in its register while earlier stages keep filling.
// ----------------------------------------------------------------------------
module packet_sequence_freshness_monitor import psfm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  psfm_in_t          item,
	output logic              result_valid,
	input  logic              result_stall,
	output psfm_out_t         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	psfm_cfg_t  cfg;
	logic       pipe_valid;
	logic       pipe_ready;
	psfm_item_t pipe_item;

	psfm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	psfm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.pipe_valid (pipe_valid),
		.pipe_ready (pipe_ready),
		.pipe_item  (pipe_item)
	);

	psfm_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.pipe_valid   (pipe_valid),
		.pipe_ready   (pipe_ready),
		.pipe_item    (pipe_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> rtl/psfm_checker.sv
// ----------------------------------------------------------------------------
// psfm_checker: Port-level checks for the freshness monitor
// Watches the result channel and relates its fields to each other.
// ----------------------------------------------------------------------------
module psfm_checker import psfm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      result_valid,
	input logic      result_stall,
	input psfm_out_t result
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("Stalled result transfer was dropped or changed.");

	a_stale_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.stale |-> result.sample_number == '1 &&
		result.event_code == EV_FIRST && !result.period_deviation)
		else $error("Stale read carries a sample number or arrival fields.");

	a_stale_counted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.stale |-> result.stale_events != 32'd0)
		else $error("Stale read is not reflected in the stale counter.");

	a_dev_counted: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.period_deviation |-> result.deviation_events != 32'd0)
		else $error("Period deviation is not reflected in the deviation counter.");

endmodule

bind packet_sequence_freshness_monitor psfm_checker u_psfm_checker (.*);
